// ===== hw/rtl/gbs_pkg.sv =====
// Shared types and constants for the greedy box suppression block.
`timescale 1ns / 1ps
`default_nettype none

package gbs_pkg;

  localparam int CoordW     = 12;
  localparam int AreaW      = 2 * CoordW;
  localparam int ThrW       = 9;
  localparam int KeptIndexW = 6;
  localparam logic [ThrW-1:0] ThrReset = 9'd115;

  // Stored box, left edge in the low bits.
  typedef struct packed {
    logic        [CoordW-1:0] height;
    logic        [CoordW-1:0] width;
    logic signed [CoordW-1:0] top;
    logic signed [CoordW-1:0] left;
  } box_t;

  localparam int BoxW   = $bits(box_t);
  localparam int EntryW = BoxW + AreaW;

  // Controller to datapath.
  typedef struct packed {
    logic load;    // capture the incoming box
    logic issue;   // read the next kept entry into the compare pipe
    logic commit;  // store the box if it survived and a slot is free, post the result
  } gbs_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic more;       // kept entries still to be read
    logic pipe_busy;  // comparisons still in flight
    logic out_free;   // result register can take a new result
  } gbs_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/gbs_if.sv =====
// Handshake channels: box input, result output and threshold write.
`timescale 1ns / 1ps
`default_nettype none

interface gbs_in_if import gbs_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic                     first_of_frame;
  logic signed [CoordW-1:0] box_left;
  logic signed [CoordW-1:0] box_top;
  logic        [CoordW-1:0] box_width;
  logic        [CoordW-1:0] box_height;

  modport source (output valid, first_of_frame, box_left, box_top, box_width, box_height,
                  input ready);
  modport sink   (input valid, first_of_frame, box_left, box_top, box_width, box_height,
                  output ready);
endinterface

interface gbs_out_if import gbs_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic                  kept;
  logic [KeptIndexW-1:0] kept_index;
  logic                  store_overflow;

  modport source (output valid, kept, kept_index, store_overflow, input ready);
  modport sink   (input valid, kept, kept_index, store_overflow, output ready);
endinterface

interface gbs_cfg_if import gbs_pkg::*;;
  logic            valid;
  logic            ready;
  logic [ThrW-1:0] iou_threshold_q8;

  modport source (output valid, iou_threshold_q8, input ready);
  modport sink   (input valid, iou_threshold_q8, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/greedy_box_suppression_core.sv =====
// Top level of the greedy box suppression block.
//
// Usage: boxes arrive on "boxes" in descending confidence order, one
// transaction per box; first_of_frame empties the kept store before that
// box is handled. Each box gets exactly one result transaction on
// "results": kept with its store slot, suppressed, or store_overflow when
// it survives but all MAX_KEPT slots are taken.
// Scan: the kept store RAM is read one entry per cycle, for the N boxes
// kept so far in the frame, into a four-stage compare pipe (overlap,
// intersection multiply, union, threshold multiply and compare); the
// result is committed once the N reads are done and the pipe has drained.
// One box is in progress at a time; the next is taken once the previous
// result sits in the result register.
// Stall: while results.ready is low the result is held and the next box
// completes its scan, then waits at commit until the register frees.
// Reset (rst, synchronous): empties the store and the result register,
// sets the threshold to 115/256. "cfg" carries the threshold and is always
// ready; it is to be written only while the block is idle, which the block does not enforce.
`timescale 1ns / 1ps
`default_nettype none

module greedy_box_suppression_core import gbs_pkg::*; #(
  parameter int MAX_KEPT = 64
) (
  input  wire logic clk,
  input  wire logic rst,
  gbs_in_if.sink    boxes,
  gbs_out_if.source results,
  gbs_cfg_if.sink   cfg
);

  gbs_cmd_t    cmd;
  gbs_status_t status;

  // sequencer
  gbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (boxes.valid),
    .in_ready (boxes.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // store, compare pipe, threshold and result register
  gbs_datapath #(
    .MAX_KEPT (MAX_KEPT)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .first_of_frame (boxes.first_of_frame),
    .box_left       (boxes.box_left),
    .box_top        (boxes.box_top),
    .box_width      (boxes.box_width),
    .box_height     (boxes.box_height),
    .cfg_valid      (cfg.valid),
    .cfg_ready      (cfg.ready),
    .cfg_data       (cfg.iou_threshold_q8),
    .out_valid      (results.valid),
    .out_ready      (results.ready),
    .kept           (results.kept),
    .kept_index     (results.kept_index),
    .store_overflow (results.store_overflow)
  );

  // a box in hand blocks further input transactions
  a_one_box: assert property (@(posedge clk) disable iff (rst)
    boxes.valid && boxes.ready |=> !boxes.ready)
    else $error("second box accepted while one is in progress");

  // no commit before every comparison has landed
  a_commit_drained: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !status.pipe_busy)
    else $error("commit with comparisons still in flight");

  // reads never go past the kept count
  a_issue_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> status.more)
    else $error("store read beyond kept entries");

  // a result is kept or overflowed, never both
  a_result_excl: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> !(results.kept && results.store_overflow))
    else $error("result both kept and overflowed");

endmodule

`default_nettype wire

// ===== hw/rtl/gbs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module gbs_ram #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 64
) (
  input  wire logic                                 clk,
  input  wire logic                                 wr_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                     wr_data,
  input  wire logic                                 rd_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/gbs_ctrl.sv =====
// Sequencer: accept, scan kept store, drain compare pipe, commit.
`timescale 1ns / 1ps
`default_nettype none

module gbs_ctrl import gbs_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire gbs_status_t status,
  output gbs_cmd_t         cmd
);

  typedef enum logic [1:0] {IDLE, SCAN, DRAIN, COMMIT} state_t;

  state_t state;

  always_comb begin
    cmd.load   = in_valid && in_ready;
    cmd.issue  = (state == SCAN) && status.more;
    cmd.commit = (state == COMMIT) && status.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      in_ready <= 1'b1;
    end else begin
      case (state)
        IDLE: begin
          if (in_valid && in_ready) begin
            state    <= SCAN;
            in_ready <= 1'b0;
          end
        end
        SCAN: begin
          if (!status.more) begin
            state <= DRAIN;
          end
        end
        DRAIN: begin
          if (!status.pipe_busy) begin
            state <= COMMIT;
          end
        end
        COMMIT: begin
          if (status.out_free) begin
            state    <= IDLE;
            in_ready <= 1'b1;
          end
        end
        default: begin
          state    <= IDLE;
          in_ready <= 1'b1;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/gbs_datapath.sv =====
// Box registers, kept store, pipelined IoU compare and result register.
`timescale 1ns / 1ps
`default_nettype none

module gbs_datapath import gbs_pkg::*; #(
  parameter int MAX_KEPT = 64
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire gbs_cmd_t                 cmd,
  output gbs_status_t                   status,
  // box input payload
  input  wire logic                     first_of_frame,
  input  wire logic signed [CoordW-1:0] box_left,
  input  wire logic signed [CoordW-1:0] box_top,
  input  wire logic        [CoordW-1:0] box_width,
  input  wire logic        [CoordW-1:0] box_height,
  // threshold write
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic        [ThrW-1:0]   cfg_data,
  // result
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic                          kept,
  output logic             [KeptIndexW-1:0] kept_index,
  output logic                          store_overflow
);

  localparam int CntW  = $clog2(MAX_KEPT + 1);
  localparam int AddrW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int UniW  = AreaW + 1;
  localparam int ProdW = UniW + ThrW;

  // overlap of [lo0, lo0+len0) and [lo1, lo1+len1), zero when disjoint
  function automatic logic [CoordW-1:0] overlap_len(
    input logic signed [CoordW-1:0] lo0, input logic [CoordW-1:0] len0,
    input logic signed [CoordW-1:0] lo1, input logic [CoordW-1:0] len1
  );
    logic signed [CoordW+1:0] s0, s1, e0, e1, hi, lo;
    logic signed [CoordW+2:0] d;
    s0 = {{2{lo0[CoordW-1]}}, lo0};
    s1 = {{2{lo1[CoordW-1]}}, lo1};
    e0 = s0 + $signed({2'b00, len0});
    e1 = s1 + $signed({2'b00, len1});
    hi = (e0 < e1) ? e0 : e1;
    lo = (s0 > s1) ? s0 : s1;
    d  = {hi[CoordW+1], hi} - {lo[CoordW+1], lo};
    return (d > 0) ? d[CoordW-1:0] : '0;
  endfunction

  logic [ThrW-1:0]  thr;
  box_t             cur;
  logic [AreaW-1:0] area;
  logic [CntW-1:0]  count;
  logic [CntW-1:0]  rd_idx;
  logic             suppress;

  // compare pipe
  logic              rd_pend, s1_valid, s2_valid, s3_valid;
  logic [EntryW-1:0] rd_data;
  box_t              rd_box;
  logic [AreaW-1:0]  rd_area;
  logic [CoordW-1:0] s1_iw, s1_ih;
  logic [AreaW-1:0]  s1_karea, s2_karea;
  logic [AreaW-1:0]  s2_inter, s3_inter;
  logic [UniW-1:0]   s3_uni;
  logic [ProdW-1:0]  lhs, rhs;

  logic                       full, keep, store;
  logic [CntW+KeptIndexW-1:0] cnt_ext;

  assign rd_box  = box_t'(rd_data[BoxW-1:0]);
  assign rd_area = rd_data[EntryW-1:BoxW];

  assign full    = (count == CntW'(MAX_KEPT));
  assign keep    = !suppress;
  assign store   = cmd.commit && keep && !full;
  assign cnt_ext = {{KeptIndexW{1'b0}}, count};

  assign status.more      = (rd_idx < count);
  assign status.pipe_busy = rd_pend || s1_valid || s2_valid || s3_valid;
  assign status.out_free  = !out_valid || out_ready;

  assign cfg_ready = 1'b1;

  gbs_ram #(
    .WIDTH (EntryW),
    .DEPTH (MAX_KEPT)
  ) u_store (
    .clk     (clk),
    .wr_en   (store),
    .wr_addr (count[AddrW-1:0]),
    .wr_data ({area, cur}),
    .rd_en   (cmd.issue),
    .rd_addr (rd_idx[AddrW-1:0]),
    .rd_data (rd_data)
  );

  // inter*256 against thr*union, both exact
  assign lhs = {{(ProdW-AreaW-8){1'b0}}, s3_inter, 8'b0};
  assign rhs = thr * s3_uni;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr       <= ThrReset;
      count     <= '0;
      rd_idx    <= '0;
      rd_pend   <= 1'b0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      suppress  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        thr <= cfg_data;
      end

      rd_pend  <= cmd.issue;
      s1_valid <= rd_pend;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;

      if (cmd.load) begin
        rd_idx   <= '0;
        suppress <= 1'b0;
        if (first_of_frame) begin
          count <= '0;
        end
      end else begin
        if (cmd.issue) begin
          rd_idx <= rd_idx + 1'b1;
        end
        if (s3_valid && (lhs > rhs)) begin
          suppress <= 1'b1;
        end
        if (store) begin
          count <= count + 1'b1;
        end
      end

      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur.left   <= box_left;
      cur.top    <= box_top;
      cur.width  <= box_width;
      cur.height <= box_height;
      area       <= box_width * box_height;
    end

    s1_iw    <= overlap_len(cur.left, cur.width, rd_box.left, rd_box.width);
    s1_ih    <= overlap_len(cur.top, cur.height, rd_box.top, rd_box.height);
    s1_karea <= rd_area;

    s2_inter <= s1_iw * s1_ih;
    s2_karea <= s1_karea;

    s3_inter <= s2_inter;
    s3_uni   <= {1'b0, area} + {1'b0, s2_karea} - {1'b0, s2_inter};

    if (cmd.commit) begin
      kept           <= keep && !full;
      kept_index     <= (keep && !full) ? cnt_ext[KeptIndexW-1:0] : '0;
      store_overflow <= keep && full;
    end
  end

endmodule

`default_nettype wire
